// ===== sv/sacd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_pkg
// shared sizes, types and command/status structs of the cache directory
// ---------------------------------------------------------------------------
package sacd_pkg;

	localparam int SETS        = 64;
	localparam int WAYS        = 4;
	localparam int BLOCK_BYTES = 64;
	localparam int RRPV_BITS   = 2;

	localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
	localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SET_W     = $clog2(SETS);
	localparam int TAG_BITS  = 32 - OFF_BITS - SET_W;
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_BITS = WAY_BITS;
	localparam int CNT_BITS  = $clog2(WAYS + 1);

	localparam logic [RRPV_BITS-1:0] RRPV_MAX  = {RRPV_BITS{1'b1}};
	localparam logic [RRPV_BITS-1:0] RRPV_FILL = RRPV_MAX - 1'b1;

	localparam logic [1:0] REG_REPLACE_MODE = 2'd0;
	localparam logic [1:0] REG_WRITE_BACK   = 2'd1;
	localparam logic [1:0] REG_WRITE_ALLOC  = 2'd2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic capture;   // latch request, launch set read
		logic resolve;   // compute lookup result and update set
	} sacd_cmd_t;

	typedef struct packed {
		logic done;      // result registered this cycle
	} sacd_stat_t;

endpackage

// ===== sv/sacd_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_datapath
// set memory, tag compare, victim choice, replacement state update
// ---------------------------------------------------------------------------
module sacd_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sacd_pkg::sacd_cmd_t    cmd,
	output sacd_pkg::sacd_stat_t   stat,
	input  logic                   replace_mode,
	input  logic                   write_back_on,
	input  logic                   write_allocate_on,
	input  logic                   opcode,
	input  logic [31:0]            address,
	output logic                   hit,
	output logic [1:0]             way,
	output logic                   allocated,
	output logic                   writeback,
	output logic [31:0]            writeback_block_address,
	output logic                   forward_write
);
	import sacd_pkg::*;

	typedef logic [TAG_BITS-1:0]  tag_t;
	typedef logic [RANK_BITS-1:0] rank_t;
	typedef logic [RRPV_BITS-1:0] rrpv_t;

	// one memory row per set, all ways side by side
	tag_t  tag_mem  [SETS][WAYS];
	rank_t rank_mem [SETS][WAYS];
	rrpv_t rrpv_mem [SETS][WAYS];

	// dirty is only looked at for valid ways, so it needs no reset
	logic [WAYS-1:0] dirty_mem [SETS];

	// valid in flops so reset clears them
	logic [WAYS-1:0] valid_q [SETS];

	logic              op_q;
	logic [SET_BITS-1:0] set_q;
	tag_t              tag_q;
	tag_t              rd_tag_q  [WAYS];
	rank_t             rd_rank_q [WAYS];
	rrpv_t             rd_rrpv_q [WAYS];
	logic [WAYS-1:0]   rd_valid_q;
	logic [WAYS-1:0]   rd_dirty_q;

	logic [SET_BITS-1:0] set_in;
	assign set_in = (SETS > 1) ? SET_BITS'(address >> OFF_BITS) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			set_q <= set_in;
			tag_q <= tag_t'(address >> (OFF_BITS + SET_W));
			for (int i = 0; i < WAYS; i++) begin
				rd_tag_q[i]  <= tag_mem[set_in][i];
				rd_rank_q[i] <= rank_mem[set_in][i];
				rd_rrpv_q[i] <= rrpv_mem[set_in][i];
			end
			rd_valid_q <= valid_q[set_in];
			rd_dirty_q <= dirty_mem[set_in];
		end
	end

	// ---- lookup
	logic [WAYS-1:0]     match;
	logic                hit_c;
	logic [WAY_BITS-1:0] hit_way;
	logic                inv_any;
	logic [WAY_BITS-1:0] inv_way;
	logic [WAY_BITS-1:0] lru_way;
	rank_t               lru_top;
	logic [WAY_BITS-1:0] rr_way;
	rrpv_t               rr_top;
	logic [CNT_BITS-1:0] valid_cnt;

	always_comb begin
		hit_c = 1'b0;
		hit_way = '0;
		inv_any = 1'b0;
		inv_way = '0;
		lru_way = '0;
		lru_top = '0;
		rr_way = '0;
		rr_top = '0;
		valid_cnt = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			match[i] = rd_valid_q[i] && (rd_tag_q[i] == tag_q);
			if (match[i]) begin
				hit_c = 1'b1;
				hit_way = WAY_BITS'(i);
			end
			if (!rd_valid_q[i]) begin
				inv_any = 1'b1;
				inv_way = WAY_BITS'(i);
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			if (rd_rank_q[i] > lru_top) begin
				lru_top = rd_rank_q[i];
				lru_way = WAY_BITS'(i);
			end
			if (rd_rrpv_q[i] > rr_top) begin
				rr_top = rd_rrpv_q[i];
				rr_way = WAY_BITS'(i);
			end
			valid_cnt = valid_cnt + CNT_BITS'(rd_valid_q[i]);
		end
	end

	logic                no_alloc;
	logic                fill;
	logic [WAY_BITS-1:0] tgt_way;
	logic                aging;
	rrpv_t               age_add;
	logic                wb_c;
	logic [CNT_BITS-1:0] old_rank;

	always_comb begin
		no_alloc = !hit_c && (op_q == OP_WRITE) && !write_allocate_on;
		fill     = !hit_c && !no_alloc;
		aging    = fill && !inv_any && replace_mode;
		age_add  = RRPV_MAX - rr_top;
		if (hit_c)
			tgt_way = hit_way;
		else if (inv_any)
			tgt_way = inv_way;
		else if (replace_mode)
			tgt_way = rr_way;
		else
			tgt_way = lru_way;
		wb_c = fill && write_back_on && rd_valid_q[tgt_way] && rd_dirty_q[tgt_way];
		old_rank = rd_valid_q[tgt_way] ? CNT_BITS'(rd_rank_q[tgt_way]) : valid_cnt;
	end

	// ---- write back the set row
	always_ff @(posedge clk) begin
		if (cmd.resolve && !no_alloc) begin
			for (int i = 0; i < WAYS; i++) begin
				if (WAY_BITS'(i) == tgt_way) begin
					rank_mem[set_q][i] <= '0;
					rrpv_mem[set_q][i] <= hit_c ? '0 : RRPV_FILL;
				end else begin
					if (rd_valid_q[i] && (CNT_BITS'(rd_rank_q[i]) < old_rank))
						rank_mem[set_q][i] <= rd_rank_q[i] + 1'b1;
					if (aging)
						rrpv_mem[set_q][i] <= rd_rrpv_q[i] + age_add;
				end
			end
			if (fill) begin
				tag_mem[set_q][tgt_way]   <= tag_q;
				dirty_mem[set_q][tgt_way] <= (op_q == OP_WRITE);
			end else if (op_q == OP_WRITE) begin
				dirty_mem[set_q][tgt_way] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++)
				valid_q[s] <= '0;
		end else if (cmd.resolve) begin
			if (fill)
				valid_q[set_q][tgt_way] <= 1'b1;
		end
	end

	// ---- result register
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			hit           <= hit_c;
			way           <= no_alloc ? 2'd0 : 2'(tgt_way);
			allocated     <= fill;
			writeback     <= wb_c;
			writeback_block_address <= wb_c ?
				(32'(rd_tag_q[tgt_way]) << (OFF_BITS + SET_W)) |
				(32'(set_q) << OFF_BITS) & ((SETS > 1) ? 32'hFFFF_FFFF : 32'h0) : 32'd0;
			forward_write <= (op_q == OP_WRITE) && (no_alloc || (hit_c && !write_back_on));
		end
	end

	assign stat.done = cmd.resolve;

	a_fill_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve |-> !(fill && hit_c)) else $error("fill on hit");
	a_wb_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve && wb_c |-> fill && write_back_on) else $error("bad writeback");
	a_filled_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve && fill |=> valid_q[$past(set_q)][$past(tgt_way)])
		else $error("fill not valid");

endmodule

// ===== sv/sacd_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_ctrl
// sequencer: capture, resolve, hold result until taken
// ---------------------------------------------------------------------------
module sacd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sacd_pkg::sacd_cmd_t  cmd,
	input  sacd_pkg::sacd_stat_t stat
);
	import sacd_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_OUT} state_t;
	state_t state_q;

	logic out_take;
	assign out_take = out_valid && !out_stall;

	// next item may enter while the result is being taken
	assign in_stall    = !(state_q == ST_IDLE || (state_q == ST_OUT && out_take));
	assign cmd.capture = in_valid && !in_stall;
	assign cmd.resolve = (state_q == ST_LOOK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q   <= ST_OUT;
					out_valid <= stat.done;
				end
				ST_OUT: begin
					if (out_take) begin
						out_valid <= 1'b0;
						state_q   <= cmd.capture ? ST_LOOK : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.resolve)) else $error("capture during resolve");
	a_valid_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve |=> out_valid) else $error("result lost");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule

// ===== sv/set_assoc_cache_directory.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_cache_directory
// tag directory of a set-associative cache, LRU or SRRIP replacement
// ---------------------------------------------------------------------------
// input channel: in_valid/in_stall carry opcode and address; a transfer
//   takes place when in_valid is high and in_stall low
// output channel: out_valid/out_stall carry hit, way, allocated,
//   writeback, writeback_block_address and forward_write
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data,
//   written only while idle, a rule for the user that the block does
//   not enforce; unknown indexes are ignored
// the input transfer registers the request and its set row; the compare
//   and row update then register the result and raise out_valid
// a new access is taken only once the result of the last one is taken,
//   and it can be taken in the same cycle as that result
// reset: all ways invalid, LRU mode, write-back and write allocate on;
//   dirty bits are not reset; no clearing pass is needed
// while a result waits under out_stall it holds and no new input is taken
// ---------------------------------------------------------------------------
module set_assoc_cache_directory (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [1:0]  way,
	output logic        allocated,
	output logic        writeback,
	output logic [31:0] writeback_block_address,
	output logic        forward_write,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);
	import sacd_pkg::*;

	sacd_cmd_t  cmd;
	sacd_stat_t stat;
	logic replace_mode_q, write_back_on_q, write_allocate_on_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_mode_q      <= 1'b0;
			write_back_on_q     <= 1'b1;
			write_allocate_on_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_REPLACE_MODE: replace_mode_q      <= cfg_data;
				REG_WRITE_BACK:   write_back_on_q     <= cfg_data;
				REG_WRITE_ALLOC:  write_allocate_on_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sacd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	sacd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.replace_mode(replace_mode_q), .write_back_on(write_back_on_q),
		.write_allocate_on(write_allocate_on_q),
		.opcode(opcode), .address(address),
		.hit(hit), .way(way), .allocated(allocated), .writeback(writeback),
		.writeback_block_address(writeback_block_address),
		.forward_write(forward_write)
	);

endmodule

// ===== verif/set_assoc_cache_directory_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_cache_directory_tb
// self-checking bench for the cache tag directory: a behavioral directory
// model predicts hit, way, fill, write-back and forwarding for each access,
// results are compared in order under random input gaps and output stalls
// ---------------------------------------------------------------------------
module set_assoc_cache_directory_tb;
	import sacd_pkg::*;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way;
		logic        allocated;
		logic        writeback;
		logic [31:0] wb_addr;
		logic        fwd;
	} lookup_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [31:0] address;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [1:0]  way;
	logic        allocated;
	logic        writeback;
	logic [31:0] writeback_block_address;
	logic        forward_write;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic        cfg_data;

	set_assoc_cache_directory DUT (.*);

	// directory model state
	logic                 m_lru_srrip;
	logic                 m_wb_on;
	logic                 m_walloc_on;
	logic                 m_valid [SETS][WAYS];
	logic                 m_dirty [SETS][WAYS];
	logic [TAG_BITS-1:0]  m_tag   [SETS][WAYS];
	int unsigned          m_rank  [SETS][WAYS];
	logic [RRPV_BITS-1:0] m_rrpv  [SETS][WAYS];

	lookup_t     pending_lookups[$];
	int          errors;
	int          idle_cycles;
	bit          hold_off;
	int unsigned hold_cycles;
	bit          no_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic promote_way(input int s, input int w);
		int unsigned old;
		old = 0;
		if (m_valid[s][w]) begin
			old = m_rank[s][w];
		end else begin
			for (int i = 0; i < WAYS; i++)
				if (m_valid[s][i]) old++;
		end
		for (int i = 0; i < WAYS; i++)
			if (i != w && m_valid[s][i] && m_rank[s][i] < old) m_rank[s][i]++;
		m_rank[s][w] = 0;
	endtask

	task automatic choose_victim(input int s, output int w);
		int unsigned top;
		w = -1;
		for (int i = 0; i < WAYS; i++)
			if (!m_valid[s][i] && w < 0) w = i;
		if (w >= 0) return;
		w = 0;
		top = 0;
		if (!m_lru_srrip) begin
			for (int i = 0; i < WAYS; i++)
				if (m_rank[s][i] > top) begin
					top = m_rank[s][i];
					w = i;
				end
		end else begin
			for (int i = 0; i < WAYS; i++)
				if (m_rrpv[s][i] > top) begin
					top = m_rrpv[s][i];
					w = i;
				end
			// age the whole set until the victim sits at max
			for (int i = 0; i < WAYS; i++)
				m_rrpv[s][i] = m_rrpv[s][i] + (RRPV_MAX - top[RRPV_BITS-1:0]);
		end
	endtask

	task automatic predict_lookup(input logic wr, input logic [31:0] a, output lookup_t r);
		int                  s;
		int                  w;
		logic [TAG_BITS-1:0] t;
		s = a[OFF_BITS +: SET_W];
		t = a[31 -: TAG_BITS];
		r = '0;
		for (int i = 0; i < WAYS; i++)
			if (!r.hit && m_valid[s][i] && m_tag[s][i] == t) begin
				r.hit = 1'b1;
				r.way = 2'(i);
			end
		if (r.hit) begin
			w = r.way;
			promote_way(s, w);
			m_rrpv[s][w] = '0;
			if (wr == OP_WRITE) begin
				m_dirty[s][w] = 1'b1;
				r.fwd = !m_wb_on;
			end
		end else if (wr == OP_WRITE && !m_walloc_on) begin
			r.fwd = 1'b1;
		end else begin
			choose_victim(s, w);
			r.way = 2'(w);
			if (m_wb_on && m_valid[s][w] && m_dirty[s][w]) begin
				r.writeback = 1'b1;
				r.wb_addr = {m_tag[s][w], s[SET_W-1:0], {OFF_BITS{1'b0}}};
			end
			promote_way(s, w);
			m_valid[s][w] = 1'b1;
			m_tag[s][w] = t;
			m_dirty[s][w] = (wr == OP_WRITE);
			m_rrpv[s][w] = RRPV_FILL;
			r.allocated = 1'b1;
		end
	endtask

	task automatic send_access(input logic wr, input logic [31:0] a);
		lookup_t r;
		@(negedge clk);
		opcode = wr;
		address = a;
		in_valid = 1'b1;
		predict_lookup(wr, a, r);
		pending_lookups = {pending_lookups, r};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// bursty sender: short gaps between bursts
	task automatic send_random(input logic wr, input logic [31:0] a);
		if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
		send_access(wr, a);
	endtask

	task automatic drain();
		while (pending_lookups.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_REPLACE_MODE: m_lru_srrip = d;
			REG_WRITE_BACK:   m_wb_on = d;
			REG_WRITE_ALLOC:  m_walloc_on = d;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_policy(input logic srrip, input logic wb, input logic walloc);
		drain();
		write_reg(REG_REPLACE_MODE, srrip);
		write_reg(REG_WRITE_BACK, wb);
		write_reg(REG_WRITE_ALLOC, walloc);
	endtask

	function automatic logic [31:0] make_addr(input int tag_pick, input int s);
		logic [31:0] a;
		a = $urandom;
		a[OFF_BITS +: SET_W] = SET_W'(s);
		a[31 -: TAG_BITS] = TAG_BITS'(tag_pick);
		return a;
	endfunction

	task automatic test_directed();
		// fill one set, hit each way, then evict with dirty victims
		for (int t = 0; t < 5; t++) send_access(t[0], make_addr(t, 3));
		for (int t = 1; t < 5; t++) send_access(OP_READ, make_addr(t, 3));
		send_access(OP_WRITE, make_addr(9, 3));
		send_access(OP_READ, 32'h0000_0000);
		send_access(OP_WRITE, 32'hFFFF_FFFF);
		send_access(OP_READ, 32'hFFFF_FFFF);
		send_access(OP_WRITE, 32'h0000_0000);
		send_access(OP_READ, 32'hAAAA_AAAA);
		send_access(OP_WRITE, 32'h5555_5555);
	endtask

	task automatic test_write_modes();
		set_policy(1'b0, 1'b0, 1'b0);
		send_access(OP_WRITE, make_addr(40, 7));   // miss, not allocated
		send_access(OP_READ, make_addr(40, 7));
		send_access(OP_WRITE, make_addr(40, 7));   // write-through hit
		for (int t = 41; t < 45; t++) send_access(OP_READ, make_addr(t, 7));
	endtask

	// few tags on few sets so hits and evictions are frequent
	task automatic test_random(input int n);
		for (int i = 0; i < n; i++)
			send_random($urandom_range(0, 1),
				make_addr($urandom_range(0, 6), $urandom_range(0, 3)));
	endtask

	task automatic test_backpressure();
		hold_cycles = 60;
		hold_off = 1'b1;
		for (int i = 0; i < 8; i++)
			send_access($urandom_range(0, 1), make_addr($urandom_range(0, 6), 1));
		hold_off = 1'b0;
		drain();
	endtask

	// receiver stall pattern, with quiet stretches and a forced hold-off
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off && hold_cycles != 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else if (no_stall) begin
				out_stall = 1'b0;
			end else begin
				out_stall = ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin
		no_stall = 1'b0;
		forever begin
			repeat ($urandom_range(50, 300)) @(negedge clk);
			no_stall = ~no_stall;
		end
	end

	// result checker
	always @(posedge clk) begin
		lookup_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result transfer", $time);
				errors++;
			end else begin
				e = pending_lookups.pop_front();
				if (hit !== e.hit || way !== e.way || allocated !== e.allocated
					|| writeback !== e.writeback
					|| writeback_block_address !== e.wb_addr
					|| forward_write !== e.fwd) begin
					$display("%0t: mismatch expected h%b w%0d a%b wb%b %h f%b got h%b w%0d a%b wb%b %h f%b",
						$time, e.hit, e.way, e.allocated, e.writeback, e.wb_addr, e.fwd,
						hit, way, allocated, writeback, writeback_block_address,
						forward_write);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		hold_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_READ;
		address = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_REPLACE_MODE;
		cfg_data = 1'b0;
		m_lru_srrip = 1'b0;
		m_wb_on = 1'b1;
		m_walloc_on = 1'b1;
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < WAYS; w++) begin
				m_valid[s][w] = 1'b0;
				m_dirty[s][w] = 1'b0;
				m_tag[s][w] = '0;
				m_rank[s][w] = 0;
				m_rrpv[s][w] = '0;
			end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(150);
		test_backpressure();
		set_policy(1'b1, 1'b1, 1'b1);
		test_directed();
		test_random(200);
		test_write_modes();
		test_random(100);
		set_policy(1'b1, 1'b0, 1'b1);
		test_random(100);
		set_policy(1'b0, 1'b1, 1'b0);
		test_random(100);
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
